// ----- rtl/voxel_phantom_pattern_assert.svh -----
// Assertion macros for the voxel phantom pattern generator.
`ifndef VOXEL_PHANTOM_PATTERN_ASSERT_SVH
`define VOXEL_PHANTOM_PATTERN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VPP_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vpp assertion failed");
`define VPP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vpp assertion failed");
`else
`define VPP_ASSERT_IMPL(lbl, pre, post)
`define VPP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- rtl/vpp_pkg.sv -----
// Shared types and constants of the voxel phantom pattern generator.
package vpp_pkg;

    localparam int AXES      = 3;
    localparam int P_W       = 30;  // point / distance in 1/256 mm
    localparam int AD_W      = 22;  // clamped distance magnitude
    localparam int AD2_W     = 44;  // squared distance
    localparam int DEN_W     = 39;  // squared divisor, remainder
    localparam int Q_W       = 30;  // quotient, Q.24 ratio
    localparam int DIV_STEPS = 30;  // one quotient bit per stage
    localparam int SUMG_W    = 24;
    localparam int SUME_W    = 32;

    localparam logic [1:0] MODE_GAUSS = 2'd0;
    localparam logic [1:0] MODE_BOX   = 2'd1;
    localparam logic [1:0] MODE_ELLIP = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_FG      = 3'd1;
    localparam logic [2:0] REG_BG      = 3'd2;
    localparam logic [2:0] REG_ORIGIN  = 3'd3;
    localparam logic [2:0] REG_SPACING = 3'd4;
    localparam logic [2:0] REG_FIRST   = 3'd5;
    localparam logic [2:0] REG_SECOND  = 3'd6;

    localparam logic [16:0]       W_ONE       = 17'd65536;
    localparam logic [SUMG_W-1:0] GAUSS_LIMIT = 24'h200000;  // 32.0 in Q.16
    localparam logic [SUME_W-1:0] ELLIP_ONE   = 32'h01000000; // 1.0 in Q.24

    typedef struct packed {
        logic far_g;   // gaussian weight forced to zero
        logic out_e;   // outside ellipsoid at once
        logic in_box;  // within box bounds on this axis
    } lane_flags_t;

endpackage

// ----- rtl/voxel_phantom_pattern.sv -----
// Voxel phantom pattern generator: top level with register file and lanes.
// Takes one voxel index per cycle, every cycle; busy never rises. The result
// appears on voxel_value with done high for one cycle, after three lane stages,
// a 30-stage divider per axis and five merge stages; the receiver cannot stall
// it and must take every word. Three axis lanes work in parallel and a merge unit
// forms the weight and blend. Registers are written through cfg_valid/cfg_ready
// (always ready); write them only while idle.
`include "voxel_phantom_pattern_assert.svh"

module voxel_phantom_pattern #(
    parameter int INDEX_BITS      = 10,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [INDEX_BITS-1:0]  index_x,
    input  logic [INDEX_BITS-1:0]  index_y,
    input  logic [INDEX_BITS-1:0]  index_z,
    output logic                   done,
    output logic signed [15:0]     voxel_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [47:0]            cfg_data
);
    localparam int IDX_USE = (INDEX_BITS < 10) ? INDEX_BITS : 10;
    localparam int VLEN    = 3 + vpp_pkg::DIV_STEPS + 5;

    logic [1:0]         mode_reg;
    logic signed [15:0] fg_reg, bg_reg;
    logic [47:0]        origin_reg, spacing_reg, first_reg, second_reg;
    logic [VLEN-1:0]    vld_reg;
    logic               accept;
    logic [9:0]         idx [0:vpp_pkg::AXES-1];
    logic [vpp_pkg::AXES-1:0][vpp_pkg::Q_W-1:0] ratio;
    vpp_pkg::lane_flags_t [vpp_pkg::AXES-1:0]   flags;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= vpp_pkg::MODE_GAUSS;
            fg_reg      <= '0;
            bg_reg      <= '0;
            origin_reg  <= '0;
            spacing_reg <= '0;
            first_reg   <= '0;
            second_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vpp_pkg::REG_MODE:    mode_reg    <= cfg_data[1:0];
                vpp_pkg::REG_FG:      fg_reg      <= signed'(cfg_data[15:0]);
                vpp_pkg::REG_BG:      bg_reg      <= signed'(cfg_data[15:0]);
                vpp_pkg::REG_ORIGIN:  origin_reg  <= cfg_data;
                vpp_pkg::REG_SPACING: spacing_reg <= cfg_data;
                vpp_pkg::REG_FIRST:   first_reg   <= cfg_data;
                vpp_pkg::REG_SECOND:  second_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid pipe alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[VLEN-2:0], accept};
    end

    assign done = vld_reg[VLEN-1];

    // index bits above the used width are ignored
    assign idx[0] = 10'(index_x[IDX_USE-1:0]);
    assign idx[1] = 10'(index_y[IDX_USE-1:0]);
    assign idx[2] = 10'(index_z[IDX_USE-1:0]);

    genvar a;
    generate
        for (a = 0; a < vpp_pkg::AXES; a++)
        begin : g_lane
            vpp_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .mode    (mode_reg),
                .idx     (idx[a]),
                .origin  (signed'(origin_reg[16*a +: 16])),
                .spacing (spacing_reg[16*a +: 16]),
                .first   (signed'(first_reg[16*a +: 16])),
                .second  (signed'(second_reg[16*a +: 16])),
                .ratio   (ratio[a]),
                .flags   (flags[a])
            );
        end
    endgenerate

    vpp_merge #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_merge (
        .clk   (clk),
        .mode  (mode_reg),
        .fg    (fg_reg),
        .bg    (bg_reg),
        .ratio (ratio),
        .flags (flags),
        .value (voxel_value)
    );

    // every accepted word comes out when its bit leaves the valid pipe, and only then
    `VPP_ASSERT_IMPL(a_lat_fwd, accept, ##VLEN done)
    `VPP_ASSERT_IMPL(a_lat_back, done, $past(accept, VLEN))
    `VPP_ASSERT_NEXT(a_vld_shift, vld_reg[0], vld_reg[1])

endmodule

// ----- rtl/vpp_div.sv -----
// Pipelined restoring divider: floor(num * 2^24 / den), one quotient bit per stage.
module vpp_div (
    input  logic                          clk,
    input  logic [vpp_pkg::AD2_W-1:0]     num,
    input  logic [vpp_pkg::DEN_W-1:0]     den,
    output logic [vpp_pkg::Q_W-1:0]       quo
);
    localparam int STEPS = vpp_pkg::DIV_STEPS;
    localparam int DW    = vpp_pkg::DEN_W;
    localparam int QW    = vpp_pkg::Q_W;

    logic [DW-1:0] rem_reg [0:STEPS-1];
    logic [DW-1:0] den_reg [0:STEPS-1];
    logic [5:0]    low_reg [0:STEPS-1];
    logic [QW-1:0] q_reg   [0:STEPS-1];

    genvar j;
    generate
        for (j = 0; j < STEPS; j++)
        begin : g_stage
            localparam int BIT = STEPS - 1 - j;
            logic [DW-1:0] r_in;
            logic [DW-1:0] d_in;
            logic [5:0]    l_in;
            logic [QW-1:0] q_in;
            logic          nb;
            logic [DW-1:0] sh;
            logic          ge;

            // stage inputs: the first stage takes the high dividend bits
            if (j == 0)
            begin : g_first
                assign r_in = DW'(num[vpp_pkg::AD2_W-1:6]);
                assign d_in = den;
                assign l_in = num[5:0];
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = rem_reg[j-1];
                assign d_in = den_reg[j-1];
                assign l_in = low_reg[j-1];
                assign q_in = q_reg[j-1];
            end

            // next dividend bit, zero below bit 24
            if (BIT >= 24)
            begin : g_nb
                assign nb = l_in[BIT-24];
            end
            else
            begin : g_nb0
                assign nb = 1'b0;
            end

            assign sh = {r_in[DW-2:0], nb};
            assign ge = (sh >= d_in);

            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? (sh - d_in) : sh;
                den_reg[j] <= d_in;
                low_reg[j] <= l_in;
                q_reg[j]   <= {q_in[QW-2:0], ge};
            end
        end
    endgenerate

    assign quo = q_reg[STEPS-1];

endmodule

// ----- rtl/vpp_lane.sv -----
// One axis lane: physical point, distance, range checks, squares and ratio.
module vpp_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    mode,
    input  logic [9:0]                    idx,
    input  logic signed [15:0]            origin,
    input  logic [15:0]                   spacing,
    input  logic signed [15:0]            first,
    input  logic signed [15:0]            second,
    output logic [vpp_pkg::Q_W-1:0]       ratio,
    output vpp_pkg::lane_flags_t          flags
);
    localparam int PW = vpp_pkg::P_W;

    logic signed [PW-1:0] o16, f16, s16;
    logic signed [PW-1:0] p_reg, p_next;
    logic signed [PW-1:0] d;
    logic [PW-1:0]        ad;
    logic [16:0]          sabs;
    logic [16:0]          sabs_reg;
    logic [vpp_pkg::AD_W-1:0]  ad_c, ad_reg;
    logic [vpp_pkg::AD2_W-1:0] ad2_reg;
    logic [vpp_pkg::DEN_W-1:0] den_reg;
    vpp_pkg::lane_flags_t fl_s2, fl_reg, fl_s3_reg;
    vpp_pkg::lane_flags_t fl_pipe_reg [0:vpp_pkg::DIV_STEPS-1];

    assign o16 = {{(PW-20){origin[15]}}, origin, 4'b0};
    assign f16 = {{(PW-20){first[15]}}, first, 4'b0};
    assign s16 = {{(PW-20){second[15]}}, second, 4'b0};

    // stage 1: physical point in 1/256 mm
    assign p_next = o16 + signed'({4'b0, 26'(idx) * 26'(spacing)});

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    // stage 2: distance magnitude, far / outside / inside tests
    assign d    = p_reg - f16;
    assign ad   = d[PW-1] ? PW'(-d) : PW'(d);
    assign sabs = second[15] ? 17'(-{second[15], second}) : {1'b0, second};

    always_comb
    begin
        fl_s2.far_g  = (sabs == '0) || (ad >= PW'({sabs, 7'b0}));
        fl_s2.out_e  = (sabs == '0) || (ad > PW'({sabs, 4'b0}));
        fl_s2.in_box = (p_reg >= f16) && (p_reg <= s16);
        case (mode)
            vpp_pkg::MODE_GAUSS: ad_c = fl_s2.far_g ? '0 : ad[vpp_pkg::AD_W-1:0];
            vpp_pkg::MODE_ELLIP: ad_c = fl_s2.out_e ? '0 : ad[vpp_pkg::AD_W-1:0];
            default:             ad_c = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ad_reg   <= ad_c;
        sabs_reg <= sabs;
        fl_reg   <= fl_s2;
    end

    // stage 3: squares of distance and divisor (divisor is 16*|s|)
    always_ff @(posedge clk)
    begin
        ad2_reg   <= vpp_pkg::AD2_W'(ad_reg) * vpp_pkg::AD2_W'(ad_reg);
        den_reg   <= vpp_pkg::DEN_W'(34'(sabs_reg) * 34'(sabs_reg)) << 8;
        fl_s3_reg <= fl_reg;
    end

    vpp_div u_div (
        .clk (clk),
        .num (ad2_reg),
        .den (den_reg),
        .quo (ratio)
    );

    // flags follow the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < vpp_pkg::DIV_STEPS; k++)
                fl_pipe_reg[k] <= '0;
        end
        else
        begin
            fl_pipe_reg[0] <= fl_s3_reg;
            for (int k = 1; k < vpp_pkg::DIV_STEPS; k++)
                fl_pipe_reg[k] <= fl_pipe_reg[k-1];
        end
    end

    assign flags = fl_pipe_reg[vpp_pkg::DIV_STEPS-1];

endmodule

// ----- rtl/vpp_merge.sv -----
// Merges lane ratios into a weight and blends background and foreground (zero in MODE_NONE).
module vpp_merge #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                                   clk,
    input  logic [1:0]                             mode,
    input  logic signed [15:0]                     fg,
    input  logic signed [15:0]                     bg,
    input  logic [vpp_pkg::AXES-1:0][vpp_pkg::Q_W-1:0] ratio,
    input  vpp_pkg::lane_flags_t [vpp_pkg::AXES-1:0]   flags,
    output logic signed [15:0]                     value
);
    localparam int IW     = $clog2(EXP_TABLE_DEPTH);
    localparam int PROD_W = 21 + IW + 1;

    // exp table entry i: round(65536 * exp(-16 i / depth)), fixed-point series
    function automatic logic [16:0] exp_entry(input int unsigned i);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] term;
        if (i == 0)
            return 17'd65536;
        t = ((64'(i) * 64'd16) << 32) / 64'(EXP_TABLE_DEPTH);
        u = t >> 5;
        s = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * u) >> 32) / 64'(k);
            if (k % 2 == 1)
                s = s - term;
            else
                s = s + term;
        end
        for (int n = 0; n < 5; n++)
            s = (s * s + 64'h8000_0000) >> 32;
        return 17'((s + 64'h8000) >> 16);
    endfunction

    logic [16:0] exp_rom [0:EXP_TABLE_DEPTH-1];

    genvar e;
    generate
        for (e = 0; e < EXP_TABLE_DEPTH; e++)
        begin : g_rom
            localparam logic [16:0] ENTRY = exp_entry(e);
            assign exp_rom[e] = ENTRY;
        end
    endgenerate

    logic [vpp_pkg::SUMG_W-1:0] sum_g;
    logic [vpp_pkg::SUME_W-1:0] sum_e;
    logic [20:0]       m1_sum_reg;
    logic              m1_zero_reg, m1_hard_reg;
    logic [IW-1:0]     m2_idx_reg;
    logic              m2_zero_reg, m2_hard_reg;
    logic [PROD_W-1:0] prod;
    logic [16:0]       w_next, w_reg;
    logic signed [33:0] pb_reg, pf_reg;
    logic signed [34:0] acc;
    logic signed [15:0] value_reg;

    // M1: sum the lane ratios, settle the hard decisions
    always_comb
    begin
        sum_g = '0;
        sum_e = '0;
        for (int a = 0; a < vpp_pkg::AXES; a++)
        begin
            sum_g = sum_g + vpp_pkg::SUMG_W'(ratio[a][vpp_pkg::Q_W-1:8]);
            sum_e = sum_e + vpp_pkg::SUME_W'(ratio[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        m1_sum_reg  <= sum_g[20:0];
        m1_zero_reg <= flags[0].far_g || flags[1].far_g || flags[2].far_g
                       || (sum_g >= vpp_pkg::GAUSS_LIMIT);
        if (mode == vpp_pkg::MODE_BOX)
            m1_hard_reg <= flags[0].in_box && flags[1].in_box && flags[2].in_box;
        else
            m1_hard_reg <= !(flags[0].out_e || flags[1].out_e || flags[2].out_e)
                           && (sum_e <= vpp_pkg::ELLIP_ONE);
    end

    // M2: table index
    assign prod = PROD_W'(m1_sum_reg) * PROD_W'(EXP_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        m2_idx_reg  <= prod[21 +: IW];
        m2_zero_reg <= m1_zero_reg;
        m2_hard_reg <= m1_hard_reg;
    end

    // M3: weight
    always_comb
    begin
        if (mode == vpp_pkg::MODE_GAUSS)
            w_next = m2_zero_reg ? 17'd0 : exp_rom[m2_idx_reg];
        else
            w_next = m2_hard_reg ? vpp_pkg::W_ONE : 17'd0;
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // M4: weighted products
    always_ff @(posedge clk)
    begin
        pb_reg <= 34'(bg) * 34'(signed'({1'b0, 17'(vpp_pkg::W_ONE - w_reg)}));
        pf_reg <= 34'(fg) * 34'(signed'({1'b0, w_reg}));
    end

    // rounding sum, floor shift
    assign acc = 35'(pb_reg) + 35'(pf_reg) + 35'sd32768;

    always_ff @(posedge clk)
    begin
        value_reg <= (mode == vpp_pkg::MODE_NONE) ? 16'sd0 : signed'(acc[31:16]);
    end

    assign value = value_reg;

endmodule
